@@ rtl/core/obfi_pkg.sv @@
// Shared types, constants and helpers for the bucket find-or-insert core.
`timescale 1ns / 1ps
`default_nettype none

package obfi_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OID_W     = 64;
  localparam int unsigned KEY_W     = 40;
  localparam int unsigned IDX_OUT_W = 8;

  // Default table depth.
  localparam int unsigned MAX_BUCKETS_DEF = 256;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // Capture the key and restart the scan.
    logic scan;    // Issue the next read and check the previous one.
    logic finish;  // Load the result register and append on a miss if there is room.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // The entry read last cycle matches the key.
    logic scan_done;  // All entries below the count have been checked.
    logic out_free;   // The result register can take a new result.
  } status_t;

  // The bucket key is the upper word followed by the top byte of the lower word.
  function automatic logic [KEY_W-1:0] make_key(input logic [OID_W-1:0] oid);
    make_key = {oid[63:32], oid[31:24]};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/obfi_ctrl.sv @@
// Controller state machine that sequences the search, the append and the result.
`timescale 1ns / 1ps
`default_nettype none

module obfi_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  obfi_pkg::status_t    status_i,
  output obfi_pkg::cmd_t       cmd_o
);

  obfi_pkg::state_e state_q, state_d;
  logic             accept;

  // A new request is taken only while idle.
  assign in_stall_o = (state_q != obfi_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      obfi_pkg::ST_IDLE: begin
        if (accept) state_d = obfi_pkg::ST_SCAN;
      end
      obfi_pkg::ST_SCAN: begin
        if (status_i.hit || status_i.scan_done) state_d = obfi_pkg::ST_FINISH;
      end
      obfi_pkg::ST_FINISH: begin
        if (status_i.out_free) state_d = obfi_pkg::ST_IDLE;
      end
      default: begin
        state_d = obfi_pkg::ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      obfi_pkg::ST_IDLE: begin
        cmd_o.start = accept;
      end
      obfi_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      obfi_pkg::ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obfi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted request always starts a scan.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == obfi_pkg::ST_SCAN))
    else $error("accepted request did not start a scan");

  // A pending result waits while the result register is busy.
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == obfi_pkg::ST_FINISH && !status_i.out_free)
      |=> (state_q == obfi_pkg::ST_FINISH))
    else $error("result dropped while output busy");

  // Scan is never issued together with finish or with start.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.scan && cmd_o.finish) && !(cmd_o.start && cmd_o.scan))
    else $error("conflicting commands");

endmodule

`default_nettype wire

@@ rtl/core/obfi_dp.sv @@
// Datapath: key memory, scan pointer, bucket count and result register.
`timescale 1ns / 1ps
`default_nettype none

module obfi_dp #(
  parameter int unsigned MaxBuckets = obfi_pkg::MAX_BUCKETS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire  [obfi_pkg::OID_W-1:0]       object_id_i,
  input  obfi_pkg::cmd_t                   cmd_i,
  output obfi_pkg::status_t                status_o,
  input  wire                              out_stall_i,
  output logic                             out_valid_o,
  output logic [obfi_pkg::IDX_OUT_W-1:0]   bucket_index_o,
  output logic                             newly_added_o,
  output logic                             table_full_o
);

  localparam int unsigned CntW = $clog2(MaxBuckets + 1);
  localparam int unsigned IdxW = (MaxBuckets > 1) ? $clog2(MaxBuckets) : 1;
  localparam int unsigned OutW = obfi_pkg::IDX_OUT_W;
  localparam logic [CntW-1:0] CntMax = CntW'(MaxBuckets);

  // Key memory, one read or write port used per cycle.
  logic [obfi_pkg::KEY_W-1:0] mem_q [MaxBuckets];
  logic [obfi_pkg::KEY_W-1:0] rd_data_q;

  logic [obfi_pkg::KEY_W-1:0] key_q;
  logic [CntW-1:0]            count_q, count_d;
  logic [CntW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]            cmp_idx_q;
  logic                       rd_vld_q, rd_vld_d;
  logic                       found_q, found_d;
  logic [CntW-1:0]            found_idx_q;
  logic                       rd_en;
  logic                       hit_now;
  logic                       is_full;
  logic                       wr_en;
  logic                       out_valid_q, out_valid_d;
  logic [OutW-1:0]            idx_out_q;
  logic                       new_out_q;
  logic                       full_out_q;
  logic [CntW+OutW-1:0]       found_ext;
  logic [CntW+OutW-1:0]       count_ext;

  // Scan control: read the next stored key while below the count.
  assign rd_en   = cmd_i.scan && (rd_ptr_q < count_q);
  assign hit_now = rd_vld_q && (rd_data_q == key_q);
  assign is_full = (count_q == CntMax);
  assign wr_en   = cmd_i.finish && !found_q && !is_full;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    rd_vld_d = 1'b0;
    found_d  = found_q;
    if (cmd_i.start) begin
      rd_ptr_d = '0;
      found_d  = 1'b0;
    end else if (cmd_i.scan) begin
      rd_vld_d = rd_en;
      if (rd_en) rd_ptr_d = rd_ptr_q + CntW'(1);
      if (hit_now) found_d = 1'b1;
    end
  end

  assign count_d = wr_en ? (count_q + CntW'(1)) : count_q;

  // Status back to the controller.
  assign status_o.hit       = hit_now;
  assign status_o.scan_done = (rd_ptr_q == count_q) && !rd_vld_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Key capture and compare-stage bookkeeping.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) key_q <= obfi_pkg::make_key(object_id_i);
    if (rd_en) cmp_idx_q <= rd_ptr_q;
    if (cmd_i.scan && hit_now) found_idx_q <= cmp_idx_q;
  end

  // Key memory ports.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[count_q[IdxW-1:0]] <= key_q;
    if (rd_en) rd_data_q <= mem_q[rd_ptr_q[IdxW-1:0]];
  end

  // The reported index keeps only its low byte.
  assign found_ext = {{OutW{1'b0}}, found_idx_q};
  assign count_ext = {{OutW{1'b0}}, count_q};

  // Result register, loaded when the controller finishes a request.
  assign out_valid_d = cmd_i.finish ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (found_q) begin
        idx_out_q  <= found_ext[OutW-1:0];
        new_out_q  <= 1'b0;
        full_out_q <= 1'b0;
      end else if (is_full) begin
        idx_out_q  <= '0;
        new_out_q  <= 1'b0;
        full_out_q <= 1'b1;
      end else begin
        idx_out_q  <= count_ext[OutW-1:0];
        new_out_q  <= 1'b1;
        full_out_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = idx_out_q;
  assign newly_added_o  = new_out_q;
  assign table_full_o   = full_out_q;

  // The count never passes the table depth.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("bucket count exceeds table depth");

  // An append grows the count by exactly one.
  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("append did not advance the count");

  // A result is never both an append and a full-table error.
  a_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(new_out_q && full_out_q))
    else $error("result flags both append and full");

  // Reads never go past the table depth.
  a_read_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (rd_ptr_q < CntMax))
    else $error("read beyond table depth");

endmodule

`default_nettype wire

@@ rtl/core/oid_bucket_find_or_insert_core.sv @@
// Top level of the bucket find-or-insert core: controller plus datapath.
// A request is accepted only while idle; the stored keys are then read in order until
// one matches or all below the count are checked, and the result is loaded at finish.
// A miss appends the key unless the table is full. Throughput: one request at a time;
// the next request is taken once the result is loaded, which waits on output stalls.
// Reset clears the bucket count and the handshake state; the key memory is
// not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module oid_bucket_find_or_insert_core #(
  parameter int unsigned MaxBuckets = obfi_pkg::MAX_BUCKETS_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [obfi_pkg::OID_W-1:0]            object_id_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [obfi_pkg::IDX_OUT_W-1:0]        bucket_index_o,
  output logic                                  newly_added_o,
  output logic                                  table_full_o
);

  obfi_pkg::cmd_t    cmd;
  obfi_pkg::status_t status;

  // Sequencer for search, append and result hand-off.
  obfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Key store, scan pointer and result register.
  obfi_dp #(
    .MaxBuckets (MaxBuckets)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .object_id_i    (object_id_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .bucket_index_o (bucket_index_o),
    .newly_added_o  (newly_added_o),
    .table_full_o   (table_full_o)
  );

endmodule

`default_nettype wire
